@@ hw/rtl/websocket_frame_deframer_core_macros.svh @@
// Assertion macros used by the deframer queue.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/wsdf_pkg.sv @@
// Types and constants shared by the WebSocket frame deframer.
package wsdf_pkg;

   localparam int unsigned LEN_WIDTH   = 63;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
   } wsdf_req_type;

   typedef struct packed {
      logic                 kind;
      logic                 final_fragment;
      logic [3:0]           frame_opcode;
      logic                 masked;
      logic [LEN_WIDTH-1:0] payload_length;
      logic [7:0]           payload_byte;
      logic                 last;
   } wsdf_rsp_type;

   // One classified beat handed from the parser to the output side.
   typedef struct packed {
      logic                 kind;
      logic                 final_fragment;
      logic [3:0]           frame_opcode;
      logic                 masked;
      logic [LEN_WIDTH-1:0] payload_length;
      logic [7:0]           data_byte;
      logic [7:0]           key_byte;
      logic                 last;
   } wsdf_entry_type;

   typedef struct packed {
      logic space;
      logic avail;
   } wsdf_q_status_type;

endpackage

@@ hw/rtl/wsdf_chan_if.sv @@
// Valid/ready channel interface carrying one beat of a packed payload.
interface wsdf_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/wsdf_front.sv @@
// Header parser: walks frame bytes and queues header and payload beats.
module wsdf_front import wsdf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   wsdf_chan_if.sink         req,
   input  wsdf_q_status_type q_status,
   output logic              push,
   output wsdf_entry_type    push_entry
);

   phase_type            phase_ff, phase_in;
   logic                 fin_ff, fin_in;
   logic [3:0]           opcode_ff, opcode_in;
   logic                 mask_ff, mask_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in;
   logic [LEN_WIDTH-1:0] pcount_ff, pcount_in;
   logic [31:0]          key_ff, key_in;
   logic [2:0]           cnt_ff, cnt_in;

   logic                 accept;
   logic [7:0]           b;
   logic [6:0]           code;
   logic [LEN_WIDTH-1:0] len_shift;
   logic                 len_end;
   logic                 mask_next;
   logic                 hdr_end;
   logic                 len_zero;
   logic [LEN_WIDTH-1:0] pcount_inc;
   logic                 pay_last;
   logic [7:0]           key_sel;
   logic                 hdr_push;
   logic                 pay_push;

   // Take a byte whenever the queue has room
   assign req.ready = q_status.space;
   assign accept    = req.valid && q_status.space;
   assign b         = req.payload.data_byte;
   assign code      = b[6:0];

   // Decode the byte against the current phase
   always_comb begin
      len_shift = len_ff;
      len_end   = 1'b0;
      case (phase_ff)
         PH_SECOND: begin
            len_shift = (code >= LEN_CODE_EXT16) ? '0 : LEN_WIDTH'(code);
            len_end   = (code < LEN_CODE_EXT16);
         end
         PH_EXT16: begin
            len_shift = LEN_WIDTH'({len_ff[7:0], b});
            len_end   = (cnt_ff >= 3'd1);
         end
         PH_EXT64: begin
            len_shift = {len_ff[LEN_WIDTH-9:0], b};
            len_end   = (cnt_ff >= 3'd7);
         end
         default: begin
            len_shift = len_ff;
            len_end   = 1'b0;
         end
      endcase
      mask_next  = (phase_ff == PH_SECOND) ? b[7] : mask_ff;
      hdr_end    = (len_end && !mask_next) || ((phase_ff == PH_KEY) && (cnt_ff >= 3'd3));
      len_zero   = (len_shift == '0);
      pcount_inc = pcount_ff + LEN_WIDTH'(1);
      pay_last   = (pcount_inc >= len_ff);
   end

   // Select the key byte for this payload position, most significant first
   always_comb begin
      case (pcount_ff[1:0])
         2'd0:    key_sel = key_ff[31:24];
         2'd1:    key_sel = key_ff[23:16];
         2'd2:    key_sel = key_ff[15:8];
         default: key_sel = key_ff[7:0];
      endcase
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_FIRST: begin
               phase_in = PH_SECOND;
            end
            PH_SECOND, PH_EXT16, PH_EXT64: begin
               if ((phase_ff == PH_SECOND) && (code == LEN_CODE_EXT16)) begin
                  phase_in = PH_EXT16;
               end else if ((phase_ff == PH_SECOND) && (code == LEN_CODE_EXT64)) begin
                  phase_in = PH_EXT64;
               end else if (hdr_end) begin
                  phase_in = len_zero ? PH_FIRST : PH_PAYLOAD;
               end else if (len_end) begin
                  phase_in = PH_KEY;
               end
            end
            PH_KEY: begin
               if (hdr_end) begin
                  phase_in = len_zero ? PH_FIRST : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (pay_last) begin
                  phase_in = PH_FIRST;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   // Field updates and queue beats
   always_comb begin
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      pcount_in = pcount_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      hdr_push  = 1'b0;
      pay_push  = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_FIRST: begin
               fin_in    = b[7];
               opcode_in = b[3:0];
               mask_in   = 1'b0;
               len_in    = '0;
               key_in    = '0;
               pcount_in = '0;
               cnt_in    = '0;
            end
            PH_SECOND: begin
               mask_in = b[7];
               len_in  = len_shift;
               cnt_in  = '0;
            end
            PH_EXT16, PH_EXT64: begin
               len_in = len_shift;
               cnt_in = len_end ? 3'd0 : cnt_ff + 3'd1;
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], b};
               cnt_in = hdr_end ? 3'd0 : cnt_ff + 3'd1;
            end
            PH_PAYLOAD: begin
               pay_push  = 1'b1;
               pcount_in = pcount_inc;
               if (pay_last) begin
                  cnt_in = '0;
               end
            end
            default: begin
               cnt_in = '0;
            end
         endcase
         // Close the header on its final byte
         if (hdr_end && (phase_ff != PH_PAYLOAD) && (phase_ff != PH_FIRST)) begin
            hdr_push  = 1'b1;
            pcount_in = '0;
            cnt_in    = '0;
         end
      end
   end

   assign push = hdr_push || pay_push;

   always_comb begin
      push_entry.kind           = pay_push ? KIND_PAYLOAD : KIND_HEADER;
      push_entry.final_fragment = fin_in;
      push_entry.frame_opcode   = opcode_in;
      push_entry.masked         = mask_in;
      push_entry.payload_length = len_in;
      push_entry.data_byte      = pay_push ? b : 8'd0;
      push_entry.key_byte       = pay_push ? key_sel : 8'd0;
      push_entry.last           = pay_push ? pay_last : len_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         pcount_ff <= '0;
         key_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         pcount_ff <= pcount_in;
         key_ff    <= key_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hw/rtl/wsdf_queue.sv @@
// Short FIFO of classified beats between the parser and the output stage.
`include "websocket_frame_deframer_core_macros.svh"

module wsdf_queue import wsdf_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wsdf_entry_type    push_entry,
   input  logic              pop,
   output wsdf_entry_type    pop_entry,
   output wsdf_q_status_type q_status
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   wsdf_entry_type        entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign q_status.space = (count_ff < CntWidth'(Depth));
   assign q_status.avail = (count_ff != '0);
   assign pop_entry      = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `WSDF_ASSERT_NOW(a_no_push_full, clock, reset, push, q_status.space, "push into full queue")
   `WSDF_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, q_status.avail, "pop from empty queue")
   `WSDF_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, count_ff != '0, "push lost")

endmodule

@@ hw/rtl/wsdf_back.sv @@
// Output stage: unmasks queued beats into a registered result channel.
module wsdf_back import wsdf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   wsdf_chan_if.source       rsp,
   input  wsdf_q_status_type q_status,
   input  wsdf_entry_type    pop_entry,
   output logic              pop
);

   logic         rsp_valid_ff, rsp_valid_in;
   wsdf_rsp_type rsp_data_ff, rsp_data_in;

   // Refill the output register when it is empty or being drained
   assign pop = q_status.avail && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.kind           = pop_entry.kind;
         rsp_data_in.final_fragment = pop_entry.final_fragment;
         rsp_data_in.frame_opcode   = pop_entry.frame_opcode;
         rsp_data_in.masked         = pop_entry.masked;
         rsp_data_in.payload_length = pop_entry.payload_length;
         rsp_data_in.payload_byte   = pop_entry.data_byte ^ pop_entry.key_byte;
         rsp_data_in.last           = pop_entry.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the beat until it is taken
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

@@ hw/rtl/websocket_frame_deframer_core.sv @@
// WebSocket frame deframer: raw frame bytes in, header and unmasked payload beats out.
//
// req_chan carries one raw stream byte per beat. rsp_chan returns one header
// beat per frame, once the last header byte (length or masking key) is in,
// then one beat per payload byte, XORed with the masking key byte for its
// position. The final beat of a frame has last set; for an empty frame that
// is the header beat. Header bytes themselves produce no beat.
// Throughput is one byte per cycle while the queue has room: the parser
// updates its header fields as each byte is accepted. After its byte is
// accepted, a result is written into the beat queue, then moved into the
// output register once that register is empty or being drained.
// A stalled receiver holds the output register; the parser keeps taking
// bytes until the queue (QueueDepth beats) fills, then drops req_chan.ready.
// Bytes that produce no result also wait while the queue is full.
// Synchronous reset returns the parser to the first header byte and empties
// the queue and the output register; no clearing sweep is needed.
module websocket_frame_deframer_core import wsdf_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   wsdf_chan_if.sink   req_chan,
   wsdf_chan_if.source rsp_chan
);

   logic              push;
   logic              pop;
   wsdf_entry_type    push_entry;
   wsdf_entry_type    pop_entry;
   wsdf_q_status_type q_status;

   wsdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   wsdf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   wsdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rsp       (rsp_chan),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop)
   );

endmodule
